// ===== rtl/tdp_pkg.sv =====
// Shared constants and types for the trial-division primality core.
`default_nettype none

package tdp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // Divisor schedule: 3, then pairs (d, d+2) for d = 5, 11, 17, ...
    localparam int DVS_THREE = 3;
    localparam int DVS_FIRST = 5;
    localparam int DVS_PAIR  = 2;
    localparam int DVS_STEP  = 6;

    // Status from the serial divider to the sequencer.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_res;

endpackage

`default_nettype wire

// ===== rtl/tdp_div.sv =====
// Bit-serial restoring divider: one dividend bit per cycle.
`default_nettype none

module tdp_div #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_dvd,
    input  wire logic [VALUE_WIDTH-1:0] i_dvs,
    output tdp_pkg::t_div_res           o_res,
    output logic      [VALUE_WIDTH-1:0] o_quo
);
    import tdp_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_dvd, n_dvd;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_done, n_done;

    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH:0]   w_diff;
    logic                   w_ge;

    assign w_trial = {r_rem, r_dvd[VALUE_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, i_dvs};
    assign w_ge    = (w_trial >= {1'b0, i_dvs});

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd = i_dvd;
            n_rem = '0;
            n_quo = '0;
            n_cnt = CW'(VALUE_WIDTH);
        end else if (r_cnt != '0) begin
            n_dvd = {r_dvd[VALUE_WIDTH-2:0], 1'b0};
            n_rem = w_ge ? w_diff[VALUE_WIDTH-1:0] : w_trial[VALUE_WIDTH-1:0];
            n_quo = {r_quo[VALUE_WIDTH-2:0], w_ge};
            n_cnt = r_cnt - CW'(1);
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    assign o_res.done     = r_done;
    assign o_res.rem_zero = (r_rem == '0);
    assign o_quo          = r_quo;

endmodule

`default_nettype wire

// ===== rtl/trial_division_primality_core.sv =====
// Top level: trial-division primality test over 6k +/- 1 divisors.
// Negatives, 0..3 and even values answer in the cycle after start.
// Every other value runs serial divisions (launch, one bit per cycle, done): one by 3,
// then two per divisor pair d, d+2 until one of them divides n or d > n/d.
// One transaction at a time; busy is high until the result strobe. Sync reset clears control.
`default_nettype none

module trial_division_primality_core #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                               o_valid,
    output logic                               o_prime
);
    import tdp_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for a transaction
        S_DIV3 = 4'b0010,   // dividing by 3
        S_DIVA = 4'b0100,   // dividing by d (also yields n/d for the bound)
        S_DIVB = 4'b1000    // dividing by d+2
    } t_state;

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_n, n_n;       // value under test, known positive
    logic [VALUE_WIDTH-1:0] r_d, n_d;       // current 6k-1 divisor
    logic [VALUE_WIDTH-1:0] r_dvs, n_dvs;   // divisor handed to the divider
    logic                   r_go, n_go;     // divider launch pulse
    logic                   r_valid, n_valid;
    logic                   r_prime, n_prime;

    t_div_res               w_div;
    logic [VALUE_WIDTH-1:0] w_quo;
    logic [VALUE_WIDTH-1:0] w_value_u;

    assign w_value_u = $unsigned(i_value);

    tdp_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_dvd   (r_n),
        .i_dvs   (r_dvs),
        .o_res   (w_div),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_d     = r_d;
        n_dvs   = r_dvs;
        n_go    = 1'b0;
        n_valid = 1'b0;
        n_prime = r_prime;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_n = w_value_u;
                    if (w_value_u[VALUE_WIDTH-1] || w_value_u <= VALUE_WIDTH'(1)) begin
                        // negative, zero or one
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                    end else if (w_value_u <= VALUE_WIDTH'(DVS_THREE)) begin
                        n_valid = 1'b1;
                        n_prime = 1'b1;
                    end else if (!w_value_u[0]) begin
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                    end else begin
                        n_dvs   = VALUE_WIDTH'(DVS_THREE);
                        n_go    = 1'b1;
                        n_state = S_DIV3;
                    end
                end
            end
            S_DIV3: begin
                if (w_div.done) begin
                    if (w_div.rem_zero) begin
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_d     = VALUE_WIDTH'(DVS_FIRST);
                        n_dvs   = VALUE_WIDTH'(DVS_FIRST);
                        n_go    = 1'b1;
                        n_state = S_DIVA;
                    end
                end
            end
            S_DIVA: begin
                if (w_div.done) begin
                    if (r_d > w_quo) begin
                        // d*d > n: no divisor left to try
                        n_valid = 1'b1;
                        n_prime = 1'b1;
                        n_state = S_IDLE;
                    end else if (w_div.rem_zero) begin
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_dvs   = r_d + VALUE_WIDTH'(DVS_PAIR);
                        n_go    = 1'b1;
                        n_state = S_DIVB;
                    end
                end
            end
            S_DIVB: begin
                if (w_div.done) begin
                    if (w_div.rem_zero) begin
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_d     = r_d + VALUE_WIDTH'(DVS_STEP);
                        n_dvs   = r_d + VALUE_WIDTH'(DVS_STEP);
                        n_go    = 1'b1;
                        n_state = S_DIVA;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_d     <= n_d;
        r_dvs   <= n_dvs;
        r_prime <= n_prime;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_prime = r_prime;

endmodule

`default_nettype wire

// ===== rtl/tdp_chk.sv =====
// Port-level checker for the primality core, bound to the top level.
`default_nettype none

module tdp_chk #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic signed [VALUE_WIDTH-1:0] i_value,
    input wire logic                          o_valid,
    input wire logic                          o_prime
);

    // An accepted transaction either answers at once or holds busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted transaction neither answered nor busy");

    // A result is never shown while a test is still running.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Busy only drops together with a result.
    a_fell_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // Every result belongs to a transaction.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy) || $fell(busy)))
        else $error("result without a transaction");

    // Negative values answer next cycle as not prime.
    a_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_value[VALUE_WIDTH-1]) |=> (o_valid && !o_prime))
        else $error("negative value not rejected");

endmodule

bind trial_division_primality_core tdp_chk #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_tdp_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_value (i_value),
    .o_valid (o_valid),
    .o_prime (o_prime)
);

`default_nettype wire
